// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the CRC frame block. Each use
// expects signals clk and arst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRC_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc32fg assertion failed");

// Next-cycle implication, disabled during reset.
`define CRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc32fg assertion failed");

`endif

// ----- rtl/crc32fg_pkg.sv -----
// ----------------------------------------------------------------------------
// crc32fg_pkg
// Types, codes and the CRC-32 update network shared by the frame CRC
// generator/checker.
// ----------------------------------------------------------------------------
package crc32fg_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned CRC_W      = 32;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_MSB  = 32'h8000_0000;

	localparam logic [LEN_W-1:0] PAYLOAD_LENGTH_RESET = 16'd12;

	// Kind of each result word.
	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_CRC     = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_MODE     = 2'd0,
		REG_PAYLOAD_LENGTH = 2'd1
	} reg_idx_t;

	typedef enum logic {
		MODE_GENERATE = 1'b0,
		MODE_CHECK    = 1'b1
	} frame_mode_t;

	// How many result words one input byte produces, and how they are laid out.
	typedef enum logic [1:0] {
		BND_SINGLE = 2'd0,
		BND_GEN    = 2'd1,
		BND_CHK    = 2'd2
	} bundle_kind_t;

	// Everything needed to replay the results of one input byte.
	typedef struct packed {
		bundle_kind_t       bkind;
		kind_t              kind;
		logic [DATA_W-1:0]  data;
		logic [CRC_W-1:0]   crc;
		logic               ok;
	} bundle_t;

	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

	// Column i holds x^(32+i) mod P: the effect of input bit i after 32 shifts.
	function automatic crc_mat_t crc_matrix();
		crc_mat_t    m;
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r = CRC_W'(1) << i;
			for (int j = 0; j < CRC_W; j++) begin
				if ((r & CRC_MSB) != '0) begin
					r = (r << 1) ^ CRC_POLY;
				end else begin
					r = r << 1;
				end
			end
			m[i] = r;
		end
		return m;
	endfunction

	localparam crc_mat_t CRC_MAT = crc_matrix();

	// One byte of the word-mode update as a flat XOR network.
	function automatic logic [CRC_W-1:0] crc_byte_step(logic [CRC_W-1:0] crc,
			logic [DATA_W-1:0] d);
		logic [CRC_W-1:0] v;
		logic [CRC_W-1:0] res;
		v   = crc ^ {{(CRC_W-DATA_W){1'b0}}, d};
		res = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (v[i]) begin
				res = res ^ CRC_MAT[i];
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/crc32fg_intf.sv -----
// ----------------------------------------------------------------------------
// crc32fg channel interfaces
// Valid/ready channels for input bytes, result words and register writes.
// ----------------------------------------------------------------------------

// Input byte channel.
interface crc32fg_in_if;
	import crc32fg_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              frame_start;

	modport source(output valid, output data_byte, output frame_start, input ready);
	modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

// Result word channel.
interface crc32fg_out_if;
	import crc32fg_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_byte;
	logic [KIND_W-1:0] out_kind;
	logic              crc_ok;
	logic [CRC_W-1:0]  crc_value;
	logic              last;

	modport source(output valid, output out_byte, output out_kind, output crc_ok,
		output crc_value, output last, input ready);
	modport sink(input valid, input out_byte, input out_kind, input crc_ok,
		input crc_value, input last, output ready);
endinterface

// Register write channel.
interface crc32fg_cfg_if;
	import crc32fg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/crc32fg_frame.sv -----
// ----------------------------------------------------------------------------
// crc32fg_frame
// Frame state (CRC, byte count, mismatch flag) and the single-pass update for
// one registered input byte. Produces the bundle of results for that byte.
// ----------------------------------------------------------------------------
module crc32fg_frame (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  logic [crc32fg_pkg::DATA_W-1:0]       data_byte,
	input  logic                                 frame_start,
	input  crc32fg_pkg::frame_mode_t             frame_mode,
	input  logic [crc32fg_pkg::LEN_W-1:0]        payload_length,
	output crc32fg_pkg::bundle_t                 bundle
);
	import crc32fg_pkg::*;

	logic [CRC_W-1:0]  crc_q, crc_base, crc_new, crc_d;
	logic [CNT_W-1:0]  cnt_q, cnt_base, cnt_inc, cnt_over, cnt_d, len;
	logic              mis_q, mis_base, mis_now, mis_d;
	logic [1:0]        crc_idx;
	logic [DATA_W-1:0] expect_byte;

	// Next state and result bundle for the byte held in the input register.
	always_comb begin
		len = (payload_length == '0) ? CNT_W'(1) : {1'b0, payload_length};

		// A frame start clears everything before the byte is taken.
		crc_base = frame_start ? CRC_INIT : crc_q;
		cnt_base = frame_start ? '0 : cnt_q;
		mis_base = frame_start ? 1'b0 : mis_q;

		cnt_over = cnt_base - len;
		crc_idx  = cnt_over[1:0];

		// A frame left stale by a register change rearms on this byte.
		if (cnt_base >= len && (frame_mode == MODE_GENERATE || cnt_over >= CNT_W'(4))) begin
			crc_base = CRC_INIT;
			cnt_base = '0;
			mis_base = 1'b0;
		end

		crc_new = crc_byte_step(crc_base, data_byte);
		cnt_inc = cnt_base + CNT_W'(1);

		case (crc_idx)
			2'd0:    expect_byte = crc_base[31:24];
			2'd1:    expect_byte = crc_base[23:16];
			2'd2:    expect_byte = crc_base[15:8];
			default: expect_byte = crc_base[7:0];
		endcase
		mis_now = mis_base | (data_byte != expect_byte);

		bundle.bkind = BND_SINGLE;
		bundle.kind  = KIND_PAYLOAD;
		bundle.data  = data_byte;
		bundle.crc   = crc_new;
		bundle.ok    = 1'b0;
		crc_d        = crc_new;
		cnt_d        = cnt_inc;
		mis_d        = mis_base;

		if (cnt_base < len) begin
			// Payload byte; the last one in generate mode appends the CRC.
			if (cnt_inc == len && frame_mode == MODE_GENERATE) begin
				bundle.bkind = BND_GEN;
				crc_d        = CRC_INIT;
				cnt_d        = '0;
				mis_d        = 1'b0;
			end
		end else begin
			// Received CRC byte in check mode.
			bundle.kind = KIND_CRC;
			bundle.crc  = crc_base;
			crc_d       = crc_base;
			mis_d       = mis_now;
			if (crc_idx == 2'd3) begin
				bundle.bkind = BND_CHK;
				bundle.ok    = !mis_now;
				crc_d        = CRC_INIT;
				cnt_d        = '0;
				mis_d        = 1'b0;
			end
		end
	end

	// Frame state registers, updated when the byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			cnt_q <= '0;
			mis_q <= 1'b0;
		end else if (advance) begin
			crc_q <= crc_d;
			cnt_q <= cnt_d;
			mis_q <= mis_d;
		end
	end

endmodule

// ----- rtl/crc32fg_emit.sv -----
// ----------------------------------------------------------------------------
// crc32fg_emit
// Result register. Holds one input byte's bundle and hands its result words
// out one per cycle while ready is high, CRC bytes most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32fg_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  crc32fg_pkg::bundle_t bundle_in,
	output logic                 free,
	crc32fg_out_if.source        res
);
	import crc32fg_pkg::*;

	bundle_t    b_q;
	logic       valid_q;
	logic [2:0] idx_q;
	logic [2:0] last_idx;
	logic       is_last;

	// Position of the final word of the held bundle.
	always_comb begin
		case (b_q.bkind)
			BND_GEN: last_idx = 3'd4;
			BND_CHK: last_idx = 3'd1;
			default: last_idx = 3'd0;
		endcase
		is_last = (idx_q == last_idx);
		free    = !valid_q || (res.ready && is_last);
	end

	// Word counter and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && res.ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Bundle payload.
	always_ff @(posedge clk) begin
		if (load) begin
			b_q <= bundle_in;
		end
	end

	// Word selection.
	always_comb begin
		res.valid     = valid_q;
		res.out_byte  = b_q.data;
		res.out_kind  = b_q.kind;
		res.crc_ok    = 1'b0;
		res.crc_value = b_q.crc;
		res.last      = is_last;
		case (b_q.bkind)
			BND_GEN: begin
				if (idx_q != 3'd0) begin
					res.out_kind = KIND_CRC;
					case (idx_q)
						3'd1:    res.out_byte = b_q.crc[31:24];
						3'd2:    res.out_byte = b_q.crc[23:16];
						3'd3:    res.out_byte = b_q.crc[15:8];
						default: res.out_byte = b_q.crc[7:0];
					endcase
				end
			end
			BND_CHK: begin
				if (idx_q != 3'd0) begin
					res.out_kind = KIND_VERDICT;
					res.out_byte = '0;
					res.crc_ok   = b_q.ok;
				end
			end
			default: begin
			end
		endcase
	end

	`CRC_ASSERT(a_verdict_is_last, res.valid && res.out_kind == KIND_VERDICT, res.last)
	`CRC_ASSERT(a_ok_only_verdict, res.valid && res.crc_ok, res.out_kind == KIND_VERDICT)
	`CRC_ASSERT_NEXT(a_stall_holds_word, valid_q && !res.ready, valid_q && $stable(idx_q))
	`CRC_ASSERT_NEXT(a_drain_empties, valid_q && res.ready && is_last && !load, !valid_q)

endmodule

// ----- rtl/crc32_frame_generate_check.sv -----
// ----------------------------------------------------------------------------
// crc32_frame_generate_check
// CRC-32 frame generator and checker, word-mode CRC over a byte stream.
// ----------------------------------------------------------------------------
// Each accepted byte is echoed as one result word, one byte per clock while the
// result side is ready, after passing the input register and then the result
// register. In generate mode the last payload byte yields five words (echo plus
// four CRC bytes, most significant first); in check mode the fourth received
// CRC byte yields two (the byte and the verdict). The result register hands out
// one word per cycle while the result side is ready and sets the rate, and
// input is taken while the result register drains its final word. The CRC
// starts at all ones, takes each byte as a zero-extended 32-bit word, and has
// no reflection or final inversion. Register writes are accepted every cycle
// and should be made while the block is idle.
// ----------------------------------------------------------------------------
module crc32_frame_generate_check (
	input  logic          clk,
	input  logic          arst_n,
	crc32fg_in_if.sink    frame_in,
	crc32fg_out_if.source result_out,
	crc32fg_cfg_if.sink   cfg_wr
);
	import crc32fg_pkg::*;

	frame_mode_t       mode_q;
	logic [LEN_W-1:0]  len_q;
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              start_s1;
	logic              advance;
	logic              free;
	bundle_t           bundle;

	// Configuration registers.
	assign cfg_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GENERATE;
			len_q  <= PAYLOAD_LENGTH_RESET;
		end else if (cfg_wr.valid) begin
			case (reg_idx_t'(cfg_wr.index))
				REG_FRAME_MODE:     mode_q <= frame_mode_t'(cfg_wr.wdata[0]);
				REG_PAYLOAD_LENGTH: len_q  <= cfg_wr.wdata[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register handshake.
	assign advance        = valid_s1 && free;
	assign frame_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.valid && frame_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			data_s1  <= frame_in.data_byte;
			start_s1 <= frame_in.frame_start;
		end
	end

	// Frame state and per-byte update.
	crc32fg_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.data_byte      (data_s1),
		.frame_start    (start_s1),
		.frame_mode     (mode_q),
		.payload_length (len_q),
		.bundle         (bundle)
	);

	// Result register and word sequencing.
	crc32fg_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.bundle_in (bundle),
		.free      (free),
		.res       (result_out)
	);

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CRC-32 frame generator and checker. A directed
// stimulus table covers reset values, field extremes, a good and a corrupted
// check frame, a zero payload length and a frame left stale by a change of
// length. Random phases follow with new register settings, well-formed frames
// with random content, truncated frames and stray words. Every result word is
// compared with the output of a behavioural predictor of the block.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import crc32fg_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 100;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_GAP       = 11;
	localparam int N_DIRECTED    = 31;

	// An index that maps to no register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_CRC,
		ROW_CONFIG
	} row_op_t;

	// One line of the directed table. For a CRC row the data field is an XOR
	// mask applied to the correct CRC byte; for a config row length and mode
	// give the new settings.
	typedef struct packed {
		row_op_t           op;
		logic [DATA_W-1:0] data;
		logic              start;
		logic              typed;
		kind_t             first_kind;
		logic              verdict_ok;
		logic [LEN_W-1:0]  length;
		frame_mode_t       mode;
	} stim_row_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_byte;
		kind_t             out_kind;
		logic              crc_ok;
		logic [CRC_W-1:0]  crc_value;
		logic              last;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;

	crc32fg_in_if  in_ch();
	crc32fg_out_if out_ch();
	crc32fg_cfg_if cfg_ch();

	crc32_frame_generate_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(in_ch),
		.result_out(out_ch),
		.cfg_wr(cfg_ch)
	);

	// Predictor state and shadow copies of the registers.
	logic [CRC_W-1:0] crc_state;
	logic [CNT_W-1:0] byte_cnt;
	logic             mismatch_flag;
	frame_mode_t      mode_shadow;
	logic [LEN_W-1:0] length_shadow;

	result_word_t expected_words[$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  bytes_sent     = 0;
	bit  sender_burst   = 1'b0;
	bit  receiver_burst = 1'b0;
	bit  hold_request   = 1'b0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// Reset settings: generate mode, twelve payload bytes.
		'{ROW_BYTE,   8'h00, 1'b1, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'hFF, 1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h80, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h7F, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h01, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'hFE, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h55, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'hAA, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h0F, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'hF0, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h3C, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'hC3, 1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		// Check mode, one payload byte, correct CRC then one with a bad first byte.
		'{ROW_CONFIG, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd1, MODE_CHECK},
		'{ROW_BYTE,   8'hFF, 1'b1, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b1, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b0, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b0, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b1, KIND_CRC,     1'b1, 16'd0, MODE_CHECK},
		'{ROW_BYTE,   8'h00, 1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h80, 1'b0, 1'b1, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b0, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b0, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		'{ROW_CRC,    8'h00, 1'b0, 1'b1, KIND_CRC,     1'b0, 16'd0, MODE_CHECK},
		// A length of zero behaves as a length of one.
		'{ROW_CONFIG, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h5A, 1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		// Longest length, frame cut short, then a shorter length leaves it stale.
		'{ROW_CONFIG, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'hFFFF, MODE_CHECK},
		'{ROW_BYTE,   8'h11, 1'b1, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_CHECK},
		'{ROW_BYTE,   8'h22, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd0, MODE_CHECK},
		'{ROW_CONFIG, 8'h00, 1'b0, 1'b0, KIND_PAYLOAD, 1'b0, 16'd2, MODE_GENERATE},
		'{ROW_BYTE,   8'h33, 1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE},
		'{ROW_BYTE,   8'h44, 1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 16'd0, MODE_GENERATE}
	};

	// Clock and cycle limit.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Word-mode CRC update: byte zero-extended, XORed in, 32 shifts MSB first.
	function automatic logic [CRC_W-1:0] crc32_word_update(logic [CRC_W-1:0] crc,
			logic [DATA_W-1:0] d);
		logic [CRC_W-1:0] r;
		r = crc ^ {{(CRC_W-DATA_W){1'b0}}, d};
		for (int i = 0; i < CRC_W; i++) begin
			if (r[CRC_W-1]) begin
				r = (r << 1) ^ CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] effective_length();
		return (length_shadow == '0) ? CNT_W'(1) : CNT_W'(length_shadow);
	endfunction

	// CRC byte number k of the current frame, most significant first.
	function automatic logic [DATA_W-1:0] crc_byte(int k);
		if (k < 0 || k > 3) begin
			return '0;
		end
		return DATA_W'(crc_state >> (24 - 8 * k));
	endfunction

	// The CRC byte the block expects next in a check frame.
	function automatic logic [DATA_W-1:0] next_check_byte();
		return crc_byte(int'(byte_cnt) - int'(effective_length()));
	endfunction

	task automatic frame_restart();
		crc_state     = CRC_INIT;
		byte_cnt      = '0;
		mismatch_flag = 1'b0;
	endtask

	task automatic push_word(logic [DATA_W-1:0] b, kind_t k, logic ok, logic last);
		result_word_t w;
		w.out_byte  = b;
		w.out_kind  = k;
		w.crc_ok    = ok;
		w.crc_value = crc_state;
		w.last      = last;
		expected_words.push_back(w);
	endtask

	// Expected result words for one accepted input word.
	task automatic predict_frame_byte(logic [DATA_W-1:0] d, logic s);
		logic [CNT_W-1:0] n;
		int               idx;
		n = effective_length();
		if (s) begin
			frame_restart();
		end
		// A frame left past its end by a register change starts afresh.
		if (byte_cnt >= n && (mode_shadow == MODE_GENERATE || byte_cnt - n >= 4)) begin
			frame_restart();
		end
		if (byte_cnt < n) begin
			crc_state = crc32_word_update(crc_state, d);
			byte_cnt  = byte_cnt + 1'b1;
			if (byte_cnt == n && mode_shadow == MODE_GENERATE) begin
				push_word(d, KIND_PAYLOAD, 1'b0, 1'b0);
				for (int b = 0; b < 4; b++) begin
					push_word(crc_byte(b), KIND_CRC, 1'b0, b == 3);
				end
				frame_restart();
			end else begin
				push_word(d, KIND_PAYLOAD, 1'b0, 1'b1);
			end
		end else begin
			idx = int'(byte_cnt - n);
			if (d != crc_byte(idx)) begin
				mismatch_flag = 1'b1;
			end
			byte_cnt = byte_cnt + 1'b1;
			if (idx == 3) begin
				push_word(d, KIND_CRC, 1'b0, 1'b0);
				push_word('0, KIND_VERDICT, !mismatch_flag, 1'b1);
				frame_restart();
			end else begin
				push_word(d, KIND_CRC, 1'b0, 1'b1);
			end
		end
	endtask

	// Offer one input word, predict its results, then idle for a random gap.
	// A typed row replaces the kind of the first result word and the verdict.
	task automatic send_byte(input logic [DATA_W-1:0] d, input logic s,
			input logic typed = 1'b0, input kind_t first_kind = KIND_PAYLOAD,
			input logic verdict_ok = 1'b0);
		int           n0;
		int           gap;
		result_word_t w;
		in_ch.valid       <= 1'b1;
		in_ch.data_byte   <= d;
		in_ch.frame_start <= s;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		n0 = expected_words.size();
		predict_frame_byte(d, s);
		if (typed) begin
			w          = expected_words[n0];
			w.out_kind = first_kind;
			expected_words[n0] = w;
			w = expected_words[expected_words.size() - 1];
			if (w.out_kind == KIND_VERDICT) begin
				w.crc_ok = verdict_ok;
				expected_words[expected_words.size() - 1] = w;
			end
		end
		bytes_sent++;
		gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Payload of n_pay bytes, then in check mode n_crc trailing CRC bytes,
	// one of which may be corrupted.
	task automatic send_frame(input int n_pay, input int n_crc, input bit lead_start,
			input bit corrupt);
		int                bad_pos;
		logic [DATA_W-1:0] flip;
		bad_pos = $urandom_range(0, 3);
		for (int i = 0; i < n_pay; i++) begin
			send_byte(DATA_W'($urandom), lead_start && i == 0);
		end
		if (mode_shadow == MODE_CHECK) begin
			for (int k = 0; k < n_crc; k++) begin
				flip = (corrupt && k == bad_pos) ? DATA_W'($urandom_range(1, 255)) : '0;
				send_byte(next_check_byte() ^ flip, 1'b0);
			end
		end
	endtask

	// Stop offering words and wait for every expected result, then let the
	// pipeline settle before anything is reconfigured.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == REG_FRAME_MODE) begin
			mode_shadow = frame_mode_t'(val[0]);
		end else if (idx == REG_PAYLOAD_LENGTH) begin
			length_shadow = val;
		end
	endtask

	// Both registers, with a stray write to an unmapped index in between. The
	// upper bits of the mode word are random and must be ignored.
	task automatic configure(input frame_mode_t m, input logic [LEN_W-1:0] len);
		write_reg(REG_FRAME_MODE, {(CFG_DATA_W-1)'($urandom), m});
		write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
		write_reg(REG_PAYLOAD_LENGTH, len);
		cfg_ch.valid <= 1'b0;
	endtask

	// Result side: random back-pressure, an occasional long hold, and a
	// field-by-field comparison of every word taken.
	initial begin
		int           gap;
		result_word_t got;
		result_word_t want;
		wait (arst_n === 1'b1);
		forever begin
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			got.out_byte  = out_ch.out_byte;
			got.out_kind  = kind_t'(out_ch.out_kind);
			got.crc_ok    = out_ch.crc_ok;
			got.crc_value = out_ch.crc_value;
			got.last      = out_ch.last;
			if (expected_words.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word: byte %h kind %0d ok %b crc %h last %b",
					$realtime, got.out_byte, got.out_kind, got.crc_ok, got.crc_value,
					got.last);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: mismatch: expected byte %h kind %0d ok %b crc %h last %b",
						$realtime, want.out_byte, want.out_kind, want.crc_ok,
						want.crc_value, want.last);
					$display("%0t:           actual byte %h kind %0d ok %b crc %h last %b",
						$realtime, got.out_byte, got.out_kind, got.crc_ok, got.crc_value,
						got.last);
				end
			end
			if (hold_request) begin
				gap          = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				gap = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Reset, the directed table, then random phases.
	initial begin
		stim_row_t        row;
		frame_mode_t      mode_pick;
		logic [LEN_W-1:0] len_pick;
		int               pick;
		int               frames;
		int               span_len;
		int               phase;

		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.data_byte   = '0;
		in_ch.frame_start = 1'b0;
		out_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_FRAME_MODE;
		cfg_ch.wdata      = '0;
		mode_shadow       = MODE_GENERATE;
		length_shadow     = PAYLOAD_LENGTH_RESET;
		frame_restart();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			row = directed_rows[r];
			case (row.op)
				ROW_CONFIG: begin
					drain();
					configure(row.mode, row.length);
				end
				ROW_CRC: begin
					send_byte(next_check_byte() ^ row.data, row.start, row.typed,
						row.first_kind, row.verdict_ok);
				end
				default: begin
					send_byte(row.data, row.start, row.typed, row.first_kind,
						row.verdict_ok);
				end
			endcase
		end

		// The first random phase floods the block while the result side holds
		// off, so that the input stalls.
		bytes_sent = 0;
		phase      = 0;
		while (bytes_sent < RANDOM_ITEMS) begin
			drain();
			mode_pick = ($urandom_range(0, 1) == 1) ? MODE_CHECK : MODE_GENERATE;
			pick      = $urandom_range(0, 9);
			if (pick == 0) begin
				len_pick = '0;
			end else if (pick == 1) begin
				len_pick = '1;
			end else if (pick <= 3) begin
				len_pick = LEN_W'($urandom_range(6, 16));
			end else begin
				len_pick = LEN_W'($urandom_range(1, 5));
			end
			if (phase == 0) begin
				mode_pick = MODE_GENERATE;
				len_pick  = LEN_W'(3);
			end
			configure(mode_pick, len_pick);
			sender_burst   = (phase == 0) || ($urandom_range(0, 3) == 0);
			receiver_burst = ($urandom_range(0, 3) == 0);
			hold_request   = (phase == 0) || ($urandom_range(0, 11) == 0);
			frames         = (phase == 0) ? 5 : $urandom_range(1, 3);
			span_len       = (len_pick == '0) ? 1 : int'(len_pick);
			for (int f = 0; f < frames; f++) begin
				pick = (phase == 0) ? 9 : $urandom_range(0, 9);
				// Frames at the longest lengths are only ever begun.
				if (span_len > 16) begin
					pick = 1;
				end
				if (pick == 0) begin
					repeat ($urandom_range(1, 3)) begin
						send_byte(DATA_W'($urandom), 1'($urandom_range(0, 1)));
					end
				end else if (pick == 1) begin
					send_frame($urandom_range(1, (span_len > 6) ? 6 : span_len),
						$urandom_range(0, 3), 1'b1, 1'b0);
				end else begin
					send_frame(span_len, 4, $urandom_range(0, 4) != 0,
						$urandom_range(0, 2) == 0);
				end
			end
			phase++;
		end

		drain();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
